FILE: design/rldc_pkg.sv
// Package for the remote lamp dimmer controller.
// Holds the word types, the operation and move codes and the register indexes.
// No dependencies.
package rldc_pkg;

    // Remote operation codes, as carried in remote_op
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_ON        = 4'd1,
        OP_OFF       = 4'd2,
        OP_POS1      = 4'd3,
        OP_POS2      = 4'd4,
        OP_RANDOM    = 4'd5,
        OP_DIM_START = 4'd6,
        OP_KEEPALIVE = 4'd7,
        OP_DIM_STOP  = 4'd8,
        OP_REPORT    = 4'd9
    } t_op;

    // Highest defined operation code; anything above acts as OP_NONE
    localparam logic [3:0] OP_LAST = 4'd9;

    // What the back end has to do with a queued word
    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_PACKET = 2'd1,
        ACT_IGNORE = 2'd2
    } t_act_kind;

    // Move request codes
    localparam logic [1:0] MOVE_NONE   = 2'd0;
    localparam logic [1:0] MOVE_POS1   = 2'd1;
    localparam logic [1:0] MOVE_POS2   = 2'd2;
    localparam logic [1:0] MOVE_RANDOM = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 3;
    localparam int unsigned CFG_DATA_BITS = 20;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KA_TIMEOUT    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_PERIOD   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_SIZE     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINK_TIMEOUT  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEFAULT_LEVEL = 3'd4;

    // Reset values
    localparam logic [15:0] RST_KA_TIMEOUT    = 16'd900;
    localparam logic [15:0] RST_STEP_PERIOD   = 16'd180;
    localparam logic [7:0]  RST_STEP_SIZE     = 8'd16;
    localparam logic [19:0] RST_LINK_TIMEOUT  = 20'd20000;
    localparam logic [7:0]  RST_DEFAULT_LEVEL = 8'd160;
    localparam logic [7:0]  RST_LEVEL         = 8'd160;
    localparam logic [7:0]  LEVEL_MAX         = 8'd255;
    localparam logic [7:0]  LEVEL_MIN_ON      = 8'd1;

    // Classified word passed from front to back
    typedef struct packed {
        t_act_kind   kind;
        t_op         op;
        logic [7:0]  session_id;
        logic [15:0] sequence_number;
    } t_action;

    // Queue status seen by the front and back
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Configuration write
    typedef struct packed {
        logic                     we;
        logic [CFG_IDX_BITS-1:0]  index;
        logic [CFG_DATA_BITS-1:0] data;
    } t_cfg_write;

endpackage

FILE: design/rldc_in_if.sv
// Input channel of the remote lamp dimmer controller: valid/ready plus the word.
// Depends on nothing.
interface rldc_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic        packet_ok;
    logic [3:0]  remote_op;
    logic [7:0]  session_id;
    logic [15:0] sequence_number;

    modport source (output valid, command, packet_ok, remote_op, session_id,
                    sequence_number, input ready);
    modport sink   (input valid, command, packet_ok, remote_op, session_id,
                    sequence_number, output ready);
endinterface

FILE: design/rldc_out_if.sv
// Output channel of the remote lamp dimmer controller: valid/ready plus the word.
// Depends on nothing.
interface rldc_out_if;
    logic       valid;
    logic       ready;
    logic       lamp_on;
    logic [7:0] lamp_level;
    logic       lamp_command;
    logic [1:0] move_request;
    logic       report_request;
    logic       remote_online;
    logic       dimmer_running;

    modport source (output valid, lamp_on, lamp_level, lamp_command, move_request,
                    report_request, remote_online, dimmer_running, input ready);
    modport sink   (input valid, lamp_on, lamp_level, lamp_command, move_request,
                    report_request, remote_online, dimmer_running, output ready);
endinterface

FILE: design/rldc_front.sv
// Front end: accepts input words and classifies them for the back end.
// Depends on rldc_pkg and rldc_in_if.
module rldc_front (
    rldc_in_if.sink              i_in,
    input  rldc_pkg::t_q_status  i_q_status,
    output logic                 o_push,
    output rldc_pkg::t_action    o_action
);
    import rldc_pkg::*;

    // Take a word whenever the queue has room
    assign i_in.ready = !i_q_status.full;
    assign o_push     = i_in.valid && !i_q_status.full;

    // Classify: tick, valid packet, or invalid packet (result only)
    always_comb begin
        o_action.session_id      = i_in.session_id;
        o_action.sequence_number = i_in.sequence_number;
        if (!i_in.command) begin
            o_action.kind = ACT_TICK;
        end else if (i_in.packet_ok) begin
            o_action.kind = ACT_PACKET;
        end else begin
            o_action.kind = ACT_IGNORE;
        end
        // undefined codes behave as no operation
        if (i_in.remote_op > OP_LAST) begin
            o_action.op = OP_NONE;
        end else begin
            o_action.op = t_op'(i_in.remote_op);
        end
    end

endmodule

FILE: design/rldc_queue.sv
// Two-word queue between the front and back ends.
// Depends on rldc_pkg.
module rldc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rldc_pkg::t_action    i_action,
    input  logic                 i_pop,
    output rldc_pkg::t_action    o_action,
    output rldc_pkg::t_q_status  o_status
);
    import rldc_pkg::*;

    t_action    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_status.empty = (r_count == 2'd0);
    assign o_status.full  = (r_count == 2'd2);
    assign o_action       = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_action;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: design/rldc_back.sv
// Back end: lamp, dimmer and link state, configuration registers, output register.
// Depends on rldc_pkg and rldc_out_if.
module rldc_back #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rldc_pkg::t_cfg_write i_cfg,
    input  rldc_pkg::t_action    i_action,
    input  rldc_pkg::t_q_status  i_q_status,
    output logic                 o_pop,
    rldc_out_if.source           o_out
);
    import rldc_pkg::*;

    // Compare width covers both the time counter and the widest timeout
    localparam int unsigned CW = (TIME_BITS > CFG_DATA_BITS) ? TIME_BITS : CFG_DATA_BITS;

    // Configuration
    logic [15:0] r_ka_timeout;
    logic [15:0] r_step_period;
    logic [7:0]  r_step_size;
    logic [19:0] r_link_timeout;
    logic [7:0]  r_default_level;

    // State
    logic                 r_light_on,    n_light_on;
    logic [7:0]           r_level,       n_level;
    logic [7:0]           r_remembered,  n_remembered;
    logic                 r_dimming,     n_dimming;
    logic                 r_dim_down,    n_dim_down;
    logic [TIME_BITS-1:0] r_time,        n_time;
    logic [TIME_BITS-1:0] r_ka_stamp,    n_ka_stamp;
    logic [TIME_BITS-1:0] r_step_stamp,  n_step_stamp;
    logic                 r_step_due,    n_step_due;
    logic                 r_link_up,     n_link_up;
    logic [TIME_BITS-1:0] r_act_stamp,   n_act_stamp;
    logic [7:0]           r_last_sess,   n_last_sess;
    logic [15:0]          r_last_seq,    n_last_seq;

    // Output register
    logic       r_out_valid;
    logic       r_lamp_command, n_lamp_command;
    logic [1:0] r_move,         n_move;
    logic       r_report,       n_report;
    logic       r_o_light_on;
    logic [7:0] r_o_level;
    logic       r_o_link_up;
    logic       r_o_dimming;

    // Derived timing and step values
    logic [TIME_BITS-1:0] time_inc;
    logic [TIME_BITS-1:0] ka_elapsed;
    logic [TIME_BITS-1:0] step_elapsed;
    logic [TIME_BITS-1:0] act_elapsed;
    logic [7:0]           step_base;
    logic [8:0]           step_sum;
    logic [7:0]           step_next;
    logic                 duplicate;

    // Pop when a word waits and the output register is free or being emptied
    assign o_pop = !i_q_status.empty && (!r_out_valid || o_out.ready);

    assign o_out.valid          = r_out_valid;
    assign o_out.lamp_on        = r_o_light_on;
    assign o_out.lamp_level     = r_o_level;
    assign o_out.lamp_command   = r_lamp_command;
    assign o_out.move_request   = r_move;
    assign o_out.report_request = r_report;
    assign o_out.remote_online  = r_o_link_up;
    assign o_out.dimmer_running = r_o_dimming;

    // Timing differences against the advanced clock (wrapping)
    assign time_inc     = r_time + {{(TIME_BITS-1){1'b0}}, 1'b1};
    assign ka_elapsed   = time_inc - r_ka_stamp;
    assign step_elapsed = time_inc - r_step_stamp;
    assign act_elapsed  = time_inc - r_act_stamp;

    // One dimmer step from level, remembered or default level, clamped to 0..255
    always_comb begin
        if (r_light_on) begin
            step_base = r_level;
        end else if (r_remembered != 8'd0) begin
            step_base = r_remembered;
        end else begin
            step_base = r_default_level;
        end
        step_sum = {1'b0, step_base} + {1'b0, r_step_size};
        if (r_dim_down) begin
            step_next = (r_step_size > step_base) ? 8'd0 : (step_base - r_step_size);
        end else begin
            step_next = step_sum[8] ? LEVEL_MAX : step_sum[7:0];
        end
    end

    assign duplicate = (i_action.session_id == r_last_sess) &&
                       (i_action.sequence_number == r_last_seq);

    // Next state for the word at the head of the queue
    always_comb begin
        n_light_on     = r_light_on;
        n_level        = r_level;
        n_remembered   = r_remembered;
        n_dimming      = r_dimming;
        n_dim_down     = r_dim_down;
        n_time         = r_time;
        n_ka_stamp     = r_ka_stamp;
        n_step_stamp   = r_step_stamp;
        n_step_due     = r_step_due;
        n_link_up      = r_link_up;
        n_act_stamp    = r_act_stamp;
        n_last_sess    = r_last_sess;
        n_last_seq     = r_last_seq;
        n_lamp_command = 1'b0;
        n_move         = MOVE_NONE;
        n_report       = 1'b0;

        unique case (i_action.kind)
            ACT_TICK: begin
                n_time = time_inc;
                // dimmer: keepalive check first, then a step when due
                if (r_dimming) begin
                    if (CW'(ka_elapsed) > CW'(r_ka_timeout)) begin
                        n_dimming  = 1'b0;
                        n_dim_down = !r_dim_down;
                    end else if (r_step_due || (CW'(step_elapsed) >= CW'(r_step_period))) begin
                        n_step_stamp   = time_inc;
                        n_step_due     = 1'b0;
                        n_light_on     = (step_next != 8'd0);
                        n_level        = step_next;
                        n_lamp_command = 1'b1;
                        if (step_next != 8'd0) begin
                            n_remembered = step_next;
                        end
                    end
                end
                // link timeout ends any hold
                if (r_link_up && (CW'(act_elapsed) > CW'(r_link_timeout))) begin
                    n_link_up = 1'b0;
                    n_dimming = 1'b0;
                end
            end
            ACT_PACKET: begin
                n_act_stamp = r_time;
                n_link_up   = 1'b1;
                if (!duplicate) begin
                    n_last_sess = i_action.session_id;
                    n_last_seq  = i_action.sequence_number;
                    unique case (i_action.op)
                        OP_ON: begin
                            n_light_on     = 1'b1;
                            n_lamp_command = 1'b1;
                            if (r_level != 8'd0) begin
                                n_level      = r_level;
                                n_remembered = r_level;
                            end else if (r_remembered != 8'd0) begin
                                n_level      = r_remembered;
                                n_remembered = r_remembered;
                            end else begin
                                n_level      = LEVEL_MIN_ON;
                                n_remembered = LEVEL_MIN_ON;
                            end
                        end
                        OP_OFF: begin
                            n_light_on     = 1'b0;
                            n_lamp_command = 1'b1;
                            if (r_level != 8'd0) begin
                                n_remembered = r_level;
                            end
                        end
                        OP_POS1:   n_move = MOVE_POS1;
                        OP_POS2:   n_move = MOVE_POS2;
                        OP_RANDOM: n_move = MOVE_RANDOM;
                        OP_DIM_START: begin
                            n_dimming  = 1'b1;
                            n_ka_stamp = r_time;
                            n_step_due = 1'b1;
                        end
                        OP_KEEPALIVE: begin
                            n_dimming  = 1'b1;
                            n_ka_stamp = r_time;
                        end
                        OP_DIM_STOP: begin
                            if (r_dimming) begin
                                n_dimming  = 1'b0;
                                n_dim_down = !r_dim_down;
                            end
                        end
                        OP_REPORT: n_report = 1'b1;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ka_timeout    <= RST_KA_TIMEOUT;
            r_step_period   <= RST_STEP_PERIOD;
            r_step_size     <= RST_STEP_SIZE;
            r_link_timeout  <= RST_LINK_TIMEOUT;
            r_default_level <= RST_DEFAULT_LEVEL;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                CFG_KA_TIMEOUT:    r_ka_timeout    <= i_cfg.data[15:0];
                CFG_STEP_PERIOD:   r_step_period   <= i_cfg.data[15:0];
                CFG_STEP_SIZE:     r_step_size     <= i_cfg.data[7:0];
                CFG_LINK_TIMEOUT:  r_link_timeout  <= i_cfg.data[19:0];
                CFG_DEFAULT_LEVEL: r_default_level <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_on   <= 1'b0;
            r_level      <= RST_LEVEL;
            r_remembered <= RST_LEVEL;
            r_dimming    <= 1'b0;
            r_dim_down   <= 1'b0;
            r_time       <= '0;
            r_ka_stamp   <= '0;
            r_step_stamp <= '0;
            r_step_due   <= 1'b1;
            r_link_up    <= 1'b0;
            r_act_stamp  <= '0;
            r_last_sess  <= 8'd0;
            r_last_seq   <= 16'd0;
        end else if (o_pop) begin
            r_light_on   <= n_light_on;
            r_level      <= n_level;
            r_remembered <= n_remembered;
            r_dimming    <= n_dimming;
            r_dim_down   <= n_dim_down;
            r_time       <= n_time;
            r_ka_stamp   <= n_ka_stamp;
            r_step_stamp <= n_step_stamp;
            r_step_due   <= n_step_due;
            r_link_up    <= n_link_up;
            r_act_stamp  <= n_act_stamp;
            r_last_sess  <= n_last_sess;
            r_last_seq   <= n_last_seq;
        end
    end

    // Output register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register: result word
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_o_light_on   <= n_light_on;
            r_o_level      <= n_level;
            r_lamp_command <= n_lamp_command;
            r_move         <= n_move;
            r_report       <= n_report;
            r_o_link_up    <= n_link_up;
            r_o_dimming    <= n_dimming;
        end
    end

endmodule

FILE: design/remote_lamp_dimmer_controller.sv
// Remote lamp dimmer controller, top level: front end, queue and back end.
// Depends on rldc_pkg, rldc_in_if, rldc_out_if, rldc_front, rldc_queue, rldc_back.

// Takes one word per cycle on i_in while the queue has room (a 1 ms tick or a
// remote packet) and gives exactly one result word per input word on o_out, in
// order. Each word is classified into a two-entry queue; the back end executes
// the head word when the output register is free or being emptied and holds
// the result on o_out, giving one word per cycle while o_out is ready. The
// queue lets input be taken while a result waits. Configuration is to be
// written through i_cfg_we/i_cfg_index/i_cfg_data only while idle; the user is
// bound by this and the block does not enforce it. Reset is synchronous and
// active low. TIME_BITS sets the width of the millisecond time base, which wraps.
module remote_lamp_dimmer_controller #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [rldc_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [rldc_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    rldc_in_if.sink                                i_in,
    rldc_out_if.source                             o_out
);
    import rldc_pkg::*;

    t_action    front_action;
    t_action    head_action;
    t_q_status  q_status;
    t_cfg_write cfg_write;
    logic       push;
    logic       pop;

    assign cfg_write.we    = i_cfg_we;
    assign cfg_write.index = i_cfg_index;
    assign cfg_write.data  = i_cfg_data;

    // Accept and classify
    rldc_front u_front (
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_action   (front_action)
    );

    // Decoupling queue
    rldc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_action (front_action),
        .i_pop    (pop),
        .o_action (head_action),
        .o_status (q_status)
    );

    // Execute and register the result
    rldc_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg_write),
        .i_action   (head_action),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

FILE: design/rldc_checker.sv
// Port-level checker for the remote lamp dimmer controller, bound to the top.
// Depends on remote_lamp_dimmer_controller.
module rldc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_lamp_on,
    input logic [7:0] i_lamp_level,
    input logic       i_remote_online,
    input logic       i_dimmer_running
);

    // A result word stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result word withdrawn before it was taken");

    // Reset leaves no result on offer
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered straight after reset");

    // A lit lamp never shows level zero
    a_on_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_lamp_on) |-> (i_lamp_level != 8'd0))
        else $error("lamp on at level zero");

    // A hold can only run while the link is up
    a_dim_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_dimmer_running) |-> i_remote_online)
        else $error("dimmer running with link down");

endmodule

bind remote_lamp_dimmer_controller rldc_checker u_rldc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_lamp_on        (o_out.lamp_on),
    .i_lamp_level     (o_out.lamp_level),
    .i_remote_online  (o_out.remote_online),
    .i_dimmer_running (o_out.dimmer_running)
);
